@@ design/irc_tok_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IRC tokenizer package
// Word types, character codes, parse phases and error codes shared by the
// tokenizer modules.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_PFX,
        PH_CMD_LEAD,
        PH_NUM,
        PH_ALPHA,
        PH_PARAMS,
        PH_MIDDLE,
        PH_TRAIL_LEAD,
        PH_TRAIL,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_SHORT,
        ERR_EMPTY_PFX,
        ERR_NO_CMD,
        ERR_BAD_CMD,
        ERR_MANY_PARAMS,
        ERR_TOO_LONG
    } t_err;

    typedef enum logic [1:0] {
        TK_PREFIX,
        TK_COMMAND,
        TK_MIDDLE,
        TK_TRAILING
    } t_tok_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic       is_status;
        logic [1:0] token_kind;
        logic [8:0] token_start;
        logic [9:0] token_length;
        logic [3:0] param_index;
        logic [2:0] error_kind;
        logic       has_prefix;
        logic [3:0] param_count;
    } t_out_word;

    typedef struct packed {
        logic      push_a;
        logic      push_b;
        t_out_word rec_a;
        t_out_word rec_b;
    } t_push;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic t_err keep_err(input t_err cur, input t_err code);
        return (cur == ERR_OK) ? code : cur;
    endfunction

endpackage
`default_nettype wire

@@ design/irc_message_tokenizer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IRC message tokenizer
// Splits one IRC line, fed a byte per word, into prefix, command and
// parameter token words, then a status word on the last byte.
// ----------------------------------------------------------------------------
//  channel   direction  word        handshake
//  in        input      t_in_word   i_in_valid / o_in_stall
//  out       output     t_out_word  o_out_valid / i_out_stall
//
//  One byte per cycle unless stalled; a byte is parsed from the input register.
//  Each byte yields zero or one token word; the last byte adds a status word,
//  so a line of N bytes gives at most N+1 output words through a 4-word queue.
//  The input stalls while a byte is held and fewer than two entries are free.
//  Synchronous active-low reset returns the parser to start of line.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_unit #(
    parameter int MAX_PARAMS = 15,
    parameter int MAX_LINE   = 512
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire irc_tok_pkg::t_in_word  i_in_word,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output irc_tok_pkg::t_out_word      o_out_word
);
    import irc_tok_pkg::*;

    t_push push;
    logic  room;

    irc_tok_core #(
        .MAX_PARAMS (MAX_PARAMS),
        .MAX_LINE   (MAX_LINE)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_room     (room),
        .o_push     (push)
    );

    irc_tok_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire

@@ design/irc_tok_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IRC tokenizer core
// Input register, two-byte hold line and line parser; builds up to two
// result words per accepted byte.
// ----------------------------------------------------------------------------
module irc_tok_core #(
    parameter int MAX_PARAMS = 15,
    parameter int MAX_LINE   = 512
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire irc_tok_pkg::t_in_word i_in_word,
    input  wire logic                  i_room,
    output irc_tok_pkg::t_push         o_push
);
    import irc_tok_pkg::*;

    localparam int OFF_W = $clog2(MAX_LINE + 2);
    localparam int PF_W  = $clog2(MAX_PARAMS + 1);

    logic             r_in_valid, n_in_valid;
    t_in_word         r_in;
    logic [7:0]       r_held0, n_held0, r_held1, n_held1;
    logic [1:0]       r_held_cnt, n_held_cnt;
    t_phase           r_phase, n_phase;
    logic [OFF_W-1:0] r_off, n_off;
    logic [OFF_W-1:0] r_ts, n_ts;
    logic [1:0]       r_dc, n_dc;
    logic [PF_W-1:0]  r_pf, n_pf;
    logic             r_ps, n_ps;
    t_err             r_err, n_err;

    logic             in_acc, proc, line_end;
    logic [7:0]       c;
    logic [OFF_W-1:0] pos, end_pos;
    logic             end_req, tok_v, crlf_ok;
    t_tok_kind        tok_kind;
    logic [OFF_W-1:0] tok_s, tok_e, tok_len;
    logic [PF_W-1:0]  tok_idx;
    logic [31:0]      w_s, w_len, w_idx, w_pf;
    t_err             st_err;
    t_out_word        tok_w, st_w;

    assign proc       = r_in_valid && i_room;
    assign line_end   = proc && r_in.last;
    assign o_in_stall = r_in_valid && !i_room;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign n_in_valid = in_acc ? 1'b1 : (proc ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_held0    <= '0;
            r_held1    <= '0;
            r_held_cnt <= '0;
            r_phase    <= PH_LEAD;
            r_off      <= '0;
            r_ts       <= '0;
            r_dc       <= '0;
            r_pf       <= '0;
            r_ps       <= 1'b0;
            r_err      <= ERR_OK;
        end else begin
            r_in_valid <= n_in_valid;
            // drop all line state after the status word
            if (line_end) begin
                r_held0    <= '0;
                r_held1    <= '0;
                r_held_cnt <= '0;
                r_phase    <= PH_LEAD;
                r_off      <= '0;
                r_ts       <= '0;
                r_dc       <= '0;
                r_pf       <= '0;
                r_ps       <= 1'b0;
                r_err      <= ERR_OK;
            end else begin
                r_held0    <= n_held0;
                r_held1    <= n_held1;
                r_held_cnt <= n_held_cnt;
                r_phase    <= n_phase;
                r_off      <= n_off;
                r_ts       <= n_ts;
                r_dc       <= n_dc;
                r_pf       <= n_pf;
                r_ps       <= n_ps;
                r_err      <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
    end

    always_comb begin
        n_held0    = r_held0;
        n_held1    = r_held1;
        n_held_cnt = r_held_cnt;
        n_phase    = r_phase;
        n_off      = r_off;
        n_ts       = r_ts;
        n_dc       = r_dc;
        n_pf       = r_pf;
        n_ps       = r_ps;
        n_err      = r_err;
        c          = r_in.data_byte;
        pos        = r_off - OFF_W'(2);
        end_req    = 1'b0;
        end_pos    = pos;
        tok_v      = 1'b0;
        tok_kind   = TK_PREFIX;
        tok_s      = r_ts;
        tok_e      = pos;
        tok_idx    = '0;

        if (proc) begin
            if (r_off <= OFF_W'(MAX_LINE)) begin
                n_off = r_off + OFF_W'(1);
            end
            if (n_off > OFF_W'(MAX_LINE)) begin
                n_err   = ERR_TOO_LONG;
                n_phase = PH_ERR;
            end

            if (r_held_cnt == 2'd2 && n_phase != PH_DONE && n_phase != PH_ERR) begin
                if (r_held0 == CH_NUL) begin
                    end_req = 1'b1;
                    end_pos = pos;
                end else begin
                    case (n_phase)
                        PH_LEAD: begin
                            if (r_held0 == CH_COLON) begin
                                n_ts    = pos + OFF_W'(1);
                                n_phase = PH_PFX;
                            end else if (r_held0 != CH_SPACE) begin
                                n_ts = pos;
                                if (is_digit(r_held0)) begin
                                    n_phase = PH_NUM;
                                    n_dc    = 2'd1;
                                end else if (is_alpha(r_held0)) begin
                                    n_phase = PH_ALPHA;
                                end else begin
                                    n_err   = keep_err(n_err, ERR_BAD_CMD);
                                    n_phase = PH_ERR;
                                end
                            end
                        end
                        PH_PFX: begin
                            if (r_held0 == CH_SPACE) begin
                                if (pos <= r_ts) begin
                                    n_err   = keep_err(n_err, ERR_EMPTY_PFX);
                                    n_phase = PH_ERR;
                                end else begin
                                    tok_v    = 1'b1;
                                    tok_kind = TK_PREFIX;
                                    n_ps     = 1'b1;
                                    n_phase  = PH_CMD_LEAD;
                                end
                            end
                        end
                        PH_CMD_LEAD: begin
                            if (r_held0 != CH_SPACE) begin
                                n_ts = pos;
                                if (is_digit(r_held0)) begin
                                    n_phase = PH_NUM;
                                    n_dc    = 2'd1;
                                end else if (is_alpha(r_held0)) begin
                                    n_phase = PH_ALPHA;
                                end else begin
                                    n_err   = keep_err(n_err, ERR_BAD_CMD);
                                    n_phase = PH_ERR;
                                end
                            end
                        end
                        PH_NUM: begin
                            if (is_digit(r_held0) && r_dc < 2'd3) begin
                                n_dc = r_dc + 2'd1;
                            end else if (r_held0 == CH_SPACE && r_dc == 2'd3) begin
                                tok_v    = 1'b1;
                                tok_kind = TK_COMMAND;
                                n_phase  = PH_PARAMS;
                            end else begin
                                n_err   = keep_err(n_err, ERR_BAD_CMD);
                                n_phase = PH_ERR;
                            end
                        end
                        PH_ALPHA: begin
                            if (r_held0 == CH_SPACE) begin
                                tok_v    = 1'b1;
                                tok_kind = TK_COMMAND;
                                n_phase  = PH_PARAMS;
                            end else if (!is_alpha(r_held0)) begin
                                n_err   = keep_err(n_err, ERR_BAD_CMD);
                                n_phase = PH_ERR;
                            end
                        end
                        PH_PARAMS: begin
                            if (r_held0 == CH_COLON) begin
                                n_phase = PH_TRAIL_LEAD;
                            end else if (r_held0 != CH_SPACE) begin
                                if (r_pf >= PF_W'(MAX_PARAMS)) begin
                                    n_err   = keep_err(n_err, ERR_MANY_PARAMS);
                                    n_phase = PH_ERR;
                                end else begin
                                    n_ts    = pos;
                                    n_phase = PH_MIDDLE;
                                end
                            end
                        end
                        PH_MIDDLE: begin
                            if (r_held0 == CH_SPACE) begin
                                tok_v    = 1'b1;
                                tok_kind = TK_MIDDLE;
                                tok_idx  = r_pf;
                                n_pf     = r_pf + PF_W'(1);
                                n_phase  = PH_PARAMS;
                            end
                        end
                        PH_TRAIL_LEAD: begin
                            if (r_held0 != CH_SPACE) begin
                                if (r_pf >= PF_W'(MAX_PARAMS)) begin
                                    n_err   = keep_err(n_err, ERR_MANY_PARAMS);
                                    n_phase = PH_ERR;
                                end else begin
                                    n_ts    = pos;
                                    n_phase = PH_TRAIL;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            if (r_in.last && r_held_cnt != 2'd0 && !end_req) begin
                end_req = 1'b1;
                end_pos = r_off - OFF_W'(1);
            end

            if (end_req) begin
                if (!tok_v) begin
                    tok_s = n_ts;
                    tok_e = end_pos;
                end
                case (n_phase)
                    PH_LEAD, PH_CMD_LEAD: begin
                        n_err   = keep_err(n_err, ERR_NO_CMD);
                        n_phase = PH_ERR;
                    end
                    PH_PFX: begin
                        n_err   = keep_err(n_err, ERR_EMPTY_PFX);
                        n_phase = PH_ERR;
                    end
                    PH_NUM: begin
                        if (n_dc != 2'd3) begin
                            n_err   = keep_err(n_err, ERR_BAD_CMD);
                            n_phase = PH_ERR;
                        end else begin
                            tok_v    = 1'b1;
                            tok_kind = TK_COMMAND;
                            n_phase  = PH_DONE;
                        end
                    end
                    PH_ALPHA: begin
                        tok_v    = 1'b1;
                        tok_kind = TK_COMMAND;
                        n_phase  = PH_DONE;
                    end
                    PH_MIDDLE, PH_TRAIL: begin
                        tok_v    = 1'b1;
                        tok_kind = (n_phase == PH_MIDDLE) ? TK_MIDDLE : TK_TRAILING;
                        tok_idx  = n_pf;
                        n_pf     = n_pf + PF_W'(1);
                        n_phase  = PH_DONE;
                    end
                    PH_PARAMS, PH_TRAIL_LEAD: begin
                        n_phase = PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end

            if (!r_in.last) begin
                case (r_held_cnt)
                    2'd0: begin
                        n_held0    = c;
                        n_held_cnt = 2'd1;
                    end
                    2'd1: begin
                        n_held1    = c;
                        n_held_cnt = 2'd2;
                    end
                    default: begin
                        n_held0 = r_held1;
                        n_held1 = c;
                    end
                endcase
            end
        end
    end

    assign crlf_ok = (r_held_cnt != 2'd0) && (c == CH_LF) &&
                     (((r_held_cnt == 2'd2) ? r_held1 : r_held0) == CH_CR);
    assign st_err  = crlf_ok ? n_err : ERR_SHORT;

    assign tok_len = (tok_e >= tok_s) ? (tok_e - tok_s) : '0;
    assign w_s     = 32'(tok_s);
    assign w_len   = 32'(tok_len);
    assign w_idx   = 32'(tok_idx);
    assign w_pf    = 32'(n_pf);

    always_comb begin
        tok_w              = '0;
        tok_w.token_kind   = tok_kind;
        tok_w.token_start  = w_s[8:0];
        tok_w.token_length = w_len[9:0];
        tok_w.param_index  = w_idx[3:0];

        st_w             = '0;
        st_w.is_status   = 1'b1;
        st_w.error_kind  = st_err;
        st_w.has_prefix  = (st_err == ERR_OK) ? n_ps : 1'b0;
        st_w.param_count = (st_err == ERR_OK) ? w_pf[3:0] : 4'd0;
    end

    always_comb begin
        o_push.push_a = proc && (tok_v || r_in.last);
        o_push.push_b = proc && tok_v && r_in.last;
        o_push.rec_a  = tok_v ? tok_w : st_w;
        o_push.rec_b  = st_w;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERR |-> r_err != ERR_OK)
        else $error("error phase without error code");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push_b |-> o_push.push_a && o_push.rec_b.is_status)
        else $error("second word without first or not a status");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pf <= PF_W'(MAX_PARAMS))
        else $error("parameter count past limit");

endmodule
`default_nettype wire

@@ design/irc_tok_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IRC tokenizer result queue
// Four-entry queue of result words; takes up to two words per cycle and
// hands one word per cycle to the output channel unless it stalls.
// ----------------------------------------------------------------------------
module irc_tok_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire irc_tok_pkg::t_push     i_push,
    output logic                        o_room,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output irc_tok_pkg::t_out_word      o_out_word
);
    import irc_tok_pkg::*;

    t_out_word         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_word  = r_mem[r_rd];
    assign o_room      = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop         = o_out_valid && !i_out_stall;

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.push_a) + QPTR_W'(i_push.push_b);
        n_rd  = r_rd + QPTR_W'(pop);
        n_cnt = r_cnt + QCNT_W'(i_push.push_a) + QCNT_W'(i_push.push_b) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr] <= i_push.rec_a;
        end
        if (i_push.push_b) begin
            r_mem[QPTR_W'(r_wr + QPTR_W'(1))] <= i_push.rec_b;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push_a |-> r_cnt <= QCNT_W'(QUEUE_DEPTH - 2))
        else $error("push without room");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push_b |-> i_push.push_a)
        else $error("second push without first");

endmodule
`default_nettype wire

@@ test/irc_message_tokenizer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRC message tokenizer testbench
// Feeds IRC lines into the tokenizer one byte per word. A short table of
// directed lines comes first, then random lines: mostly well-formed, some
// crowded, broken or noise, then two lines at the length limit. Sender gaps
// and receiver stalls vary by phase. Every output word is compared with the
// tokens and status an in-bench line parser predicts; typed rows set the status.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_unit_tb;
    import irc_tok_pkg::*;

    localparam int MAX_PARAMS     = 15;
    localparam int MAX_LINE       = 512;
    localparam int DIR_ROWS       = 22;
    localparam int RANDOM_BYTES   = 480;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int TAIL_CYCLES    = 20;

    typedef enum logic [1:0] {
        TAIL_CRLF,
        TAIL_LF,
        TAIL_BARE
    } t_line_tail;

    typedef struct packed {
        t_line_tail tail;
        logic       typed;
        t_err       err;
        logic       pfx;
        logic [3:0] cnt;
    } t_dir_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // '#' stands for a zero byte and '^' for 8'hFF
    string dir_text [DIR_ROWS] = '{
        "", "", "PING", ":nick!u@h PRIVMSG &chan :hello world", ": CMD", ":pfx",
        "001 a b", "01 x", "0012", "PR1V", "?X", "  CMD a :   ", "CMD a#bc",
        "CMD x", "CMD", "CMD :^^", "   ", ":p  ", "A", "#", "?X", "123 :"
    };

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{TAIL_LF,   1'b1, ERR_SHORT,     1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_NO_CMD,    1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_OK,        1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_OK,        1'b1, 4'd2},
        '{TAIL_CRLF, 1'b1, ERR_EMPTY_PFX, 1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_EMPTY_PFX, 1'b0, 4'd0},
        '{TAIL_CRLF, 1'b0, ERR_OK,        1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_BAD_CMD,   1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_BAD_CMD,   1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_BAD_CMD,   1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_BAD_CMD,   1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_OK,        1'b0, 4'd1},
        '{TAIL_CRLF, 1'b0, ERR_OK,        1'b0, 4'd0},
        '{TAIL_LF,   1'b1, ERR_SHORT,     1'b0, 4'd0},
        '{TAIL_BARE, 1'b1, ERR_SHORT,     1'b0, 4'd0},
        '{TAIL_CRLF, 1'b0, ERR_OK,        1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_NO_CMD,    1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_NO_CMD,    1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_OK,        1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_NO_CMD,    1'b0, 4'd0},
        '{TAIL_LF,   1'b1, ERR_SHORT,     1'b0, 4'd0},
        '{TAIL_CRLF, 1'b1, ERR_OK,        1'b0, 4'd0}
    };

    // line parser state
    logic [7:0] held [2];
    int         n_held;
    t_phase     parse_ph;
    int         line_offset;
    int         tok_start;
    int         digits;
    int         n_params;
    logic       pfx_seen;
    t_err       line_err;

    t_out_word  due_words [$];
    logic [7:0] line_bytes [$];

    int send_gap_pct     = 17;
    int recv_stall_pct   = 80;
    int holdoff_requests = 0;
    int holdoff_served   = 0;
    int holdoff_left     = 0;
    int fail_count       = 0;
    int lines_sent       = 0;
    int bytes_sent       = 0;
    int status_words     = 0;
    int error_statuses   = 0;
    int kind_seen [4]    = '{0, 0, 0, 0};

    irc_message_tokenizer_unit #(
        .MAX_PARAMS(MAX_PARAMS),
        .MAX_LINE  (MAX_LINE)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic void clear_line();
        held[0]     = 8'h00;
        held[1]     = 8'h00;
        n_held      = 0;
        parse_ph    = PH_LEAD;
        line_offset = 0;
        tok_start   = 0;
        digits      = 0;
        n_params    = 0;
        pfx_seen    = 1'b0;
        line_err    = ERR_OK;
    endfunction

    function automatic void fail_parse(input t_err code);
        if (line_err == ERR_OK) line_err = code;
        parse_ph = PH_ERR;
    endfunction

    function automatic void push_token(input t_tok_kind kind, input int start, input int stop,
                                       input int idx);
        t_out_word w;
        w              = '0;
        w.token_kind   = kind;
        w.token_start  = 9'(start);
        w.token_length = (stop >= start) ? 10'(stop - start) : 10'd0;
        w.param_index  = 4'(idx);
        due_words.push_back(w);
    endfunction

    function automatic void begin_command(input logic [7:0] c, input int pos);
        tok_start = pos;
        if (digit_char(c)) begin
            parse_ph = PH_NUM;
            digits   = 1;
        end else if (letter_char(c)) begin
            parse_ph = PH_ALPHA;
        end else begin
            fail_parse(ERR_BAD_CMD);
        end
    endfunction

    function automatic void close_content(input int pos);
        case (parse_ph)
            PH_LEAD, PH_CMD_LEAD: fail_parse(ERR_NO_CMD);
            PH_PFX: fail_parse(ERR_EMPTY_PFX);
            PH_NUM: begin
                if (digits != 3) begin
                    fail_parse(ERR_BAD_CMD);
                end else begin
                    push_token(TK_COMMAND, tok_start, pos, 0);
                    parse_ph = PH_DONE;
                end
            end
            PH_ALPHA: begin
                push_token(TK_COMMAND, tok_start, pos, 0);
                parse_ph = PH_DONE;
            end
            PH_MIDDLE: begin
                push_token(TK_MIDDLE, tok_start, pos, n_params);
                n_params++;
                parse_ph = PH_DONE;
            end
            PH_TRAIL: begin
                push_token(TK_TRAILING, tok_start, pos, n_params);
                n_params++;
                parse_ph = PH_DONE;
            end
            PH_PARAMS, PH_TRAIL_LEAD: parse_ph = PH_DONE;
            default: ;
        endcase
    endfunction

    function automatic void scan_char(input logic [7:0] c, input int pos);
        if (parse_ph == PH_DONE || parse_ph == PH_ERR) return;
        if (c == CH_NUL) begin
            close_content(pos);
            return;
        end
        case (parse_ph)
            PH_LEAD: begin
                if (c == CH_COLON) begin
                    tok_start = pos + 1;
                    parse_ph  = PH_PFX;
                end else if (c != CH_SPACE) begin
                    begin_command(c, pos);
                end
            end
            PH_PFX: begin
                if (c == CH_SPACE) begin
                    if (pos <= tok_start) begin
                        fail_parse(ERR_EMPTY_PFX);
                    end else begin
                        push_token(TK_PREFIX, tok_start, pos, 0);
                        pfx_seen = 1'b1;
                        parse_ph = PH_CMD_LEAD;
                    end
                end
            end
            PH_CMD_LEAD: begin
                if (c != CH_SPACE) begin_command(c, pos);
            end
            PH_NUM: begin
                if (digit_char(c) && digits < 3) begin
                    digits++;
                end else if (c == CH_SPACE && digits == 3) begin
                    push_token(TK_COMMAND, tok_start, pos, 0);
                    parse_ph = PH_PARAMS;
                end else begin
                    fail_parse(ERR_BAD_CMD);
                end
            end
            PH_ALPHA: begin
                if (c == CH_SPACE) begin
                    push_token(TK_COMMAND, tok_start, pos, 0);
                    parse_ph = PH_PARAMS;
                end else if (!letter_char(c)) begin
                    fail_parse(ERR_BAD_CMD);
                end
            end
            PH_PARAMS: begin
                if (c == CH_COLON) begin
                    parse_ph = PH_TRAIL_LEAD;
                end else if (c != CH_SPACE) begin
                    if (n_params >= MAX_PARAMS) begin
                        fail_parse(ERR_MANY_PARAMS);
                    end else begin
                        tok_start = pos;
                        parse_ph  = PH_MIDDLE;
                    end
                end
            end
            PH_MIDDLE: begin
                if (c == CH_SPACE) begin
                    push_token(TK_MIDDLE, tok_start, pos, n_params);
                    n_params++;
                    parse_ph = PH_PARAMS;
                end
            end
            PH_TRAIL_LEAD: begin
                if (c != CH_SPACE) begin
                    if (n_params >= MAX_PARAMS) begin
                        fail_parse(ERR_MANY_PARAMS);
                    end else begin
                        tok_start = pos;
                        parse_ph  = PH_TRAIL;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic lst);
        int        n;
        logic      crlf_ok;
        t_err      status_err;
        t_out_word w;
        n = line_offset;
        if (line_offset <= MAX_LINE) line_offset++;
        if (line_offset > MAX_LINE) begin
            line_err = ERR_TOO_LONG;
            parse_ph = PH_ERR;
        end
        if (!lst) begin
            if (n_held >= 2) begin
                scan_char(held[0], n - 2);
                held[0] = held[1];
                held[1] = c;
            end else begin
                held[n_held] = c;
                n_held++;
            end
            return;
        end
        crlf_ok = (n_held >= 1) && (c == CH_LF) && (held[n_held - 1] == CH_CR);
        if (n_held >= 2) scan_char(held[0], n - 2);
        if (n_held >= 1) close_content(n - 1);
        status_err   = crlf_ok ? line_err : ERR_SHORT;
        w            = '0;
        w.is_status  = 1'b1;
        w.error_kind = status_err;
        if (status_err == ERR_OK) begin
            w.has_prefix  = pfx_seen;
            w.param_count = 4'(n_params);
        end
        due_words.push_back(w);
        clear_line();
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void take_word(input t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            $error("unexpected word %h", got);
            fail_count++;
            return;
        end
        want = due_words.pop_front();
        check_field("is_status", want.is_status, got.is_status);
        check_field("token_kind", want.token_kind, got.token_kind);
        check_field("token_start", want.token_start, got.token_start);
        check_field("token_length", want.token_length, got.token_length);
        check_field("param_index", want.param_index, got.param_index);
        check_field("error_kind", want.error_kind, got.error_kind);
        check_field("has_prefix", want.has_prefix, got.has_prefix);
        check_field("param_count", want.param_count, got.param_count);
        if (want.is_status) begin
            status_words++;
            if (want.error_kind != ERR_OK) error_statuses++;
        end else begin
            kind_seen[want.token_kind]++;
        end
    endfunction

    function automatic void compose_well(input int n_mid, input logic with_trail);
        logic [7:0] b;
        line_bytes.delete();
        if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) line_bytes.push_back(CH_SPACE);
        if ($urandom_range(9) < 4) begin
            line_bytes.push_back(CH_COLON);
            repeat ($urandom_range(8, 1)) line_bytes.push_back(8'($urandom_range(8'h7E, 8'h21)));
            repeat ($urandom_range(2, 1)) line_bytes.push_back(CH_SPACE);
        end
        if ($urandom_range(1) == 1) begin
            repeat ($urandom_range(8, 1)) begin
                b = 8'($urandom_range(25)) + (($urandom_range(1) == 1) ? 8'h61 : 8'h41);
                line_bytes.push_back(b);
            end
        end else begin
            repeat (3) line_bytes.push_back(8'($urandom_range(8'h39, 8'h30)));
        end
        repeat (n_mid) begin
            repeat ($urandom_range(2, 1)) line_bytes.push_back(CH_SPACE);
            b = 8'($urandom_range(8'h7E, 8'h21));
            line_bytes.push_back((b == CH_COLON) ? 8'h78 : b);
            repeat ($urandom_range(6)) line_bytes.push_back(8'($urandom_range(8'hFF, 8'h21)));
        end
        if (with_trail) begin
            line_bytes.push_back(CH_SPACE);
            line_bytes.push_back(CH_COLON);
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(3)) line_bytes.push_back(CH_SPACE);
            end else begin
                repeat ($urandom_range(12)) line_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
            end
        end
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endfunction

    function automatic void compose_random_line();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            compose_well(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3),
                         $urandom_range(1));
        end else if (pick < 68) begin
            compose_well($urandom_range(17, 14), $urandom_range(1));
        end else if (pick < 88) begin
            compose_well($urandom_range(4), $urandom_range(1));
            case ($urandom_range(4))
                0: line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom_range(255));
                1: line_bytes.delete(line_bytes.size() - 2);
                2: void'(line_bytes.pop_back());
                3: line_bytes.insert($urandom_range(line_bytes.size() - 1), CH_NUL);
                default: begin
                    while (line_bytes.size() > 1 && $urandom_range(3) != 0)
                        void'(line_bytes.pop_back());
                end
            endcase
        end else begin
            line_bytes.delete();
            repeat ($urandom_range(10, 1)) line_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    function automatic void compose_long(input int total);
        string lead;
        lead = "LONG :";
        line_bytes.delete();
        for (int k = 0; k < lead.len(); k++) line_bytes.push_back(lead[k]);
        repeat (total - lead.len() - 2) line_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endfunction

    task automatic send_line(input logic typed, input t_out_word typed_status);
        logic lst;
        for (int i = 0; i < line_bytes.size(); i++) begin
            lst = (i == line_bytes.size() - 1);
            while ($urandom_range(99) < send_gap_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_word  <= {line_bytes[i], lst};
            @(posedge clk);
            while (in_stall) @(posedge clk);
            predict_byte(line_bytes[i], lst);
            bytes_sent++;
        end
        if (typed) begin
            void'(due_words.pop_back());
            due_words.push_back(typed_status);
        end
        lines_sent++;
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) take_word(out_word);
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            out_stall <= 1'b1;
        end else if (holdoff_served != holdoff_requests) begin
            holdoff_served = holdoff_requests;
            holdoff_left   = HOLDOFF_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        t_out_word  typed_word;
        logic [7:0] b;
        int         phase_end;
        clear_line();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            line_bytes.delete();
            for (int k = 0; k < dir_text[r].len(); k++) begin
                b = dir_text[r][k];
                if (b == "#") b = CH_NUL;
                else if (b == "^") b = 8'hFF;
                line_bytes.push_back(b);
            end
            case (dir_rows[r].tail)
                TAIL_CRLF: begin
                    line_bytes.push_back(CH_CR);
                    line_bytes.push_back(CH_LF);
                end
                TAIL_LF: line_bytes.push_back(CH_LF);
                default: ;
            endcase
            typed_word             = '0;
            typed_word.is_status   = 1'b1;
            typed_word.error_kind  = dir_rows[r].err;
            typed_word.has_prefix  = dir_rows[r].pfx;
            typed_word.param_count = dir_rows[r].cnt;
            send_line(dir_rows[r].typed, typed_word);
        end

        for (int pass_no = 0; pass_no < 3; pass_no++) begin
            case (pass_no)
                0: begin
                    send_gap_pct   = 17;
                    recv_stall_pct = 80;
                end
                1: begin
                    send_gap_pct   = 80;
                    recv_stall_pct = 17;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                    holdoff_requests++;
                end
            endcase
            phase_end = bytes_sent + RANDOM_BYTES / 3;
            while (bytes_sent < phase_end) begin
                compose_random_line();
                send_line(1'b0, '0);
            end
            drain_words();
        end

        // boundary of the line length limit, last byte at and past the maximum
        compose_long(MAX_LINE);
        send_line(1'b0, '0);
        compose_long(MAX_LINE + 1);
        send_line(1'b0, '0);

        drain_words();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d lines (%0d bytes): %0d status words, %0d of them errors",
                 lines_sent, bytes_sent, status_words, error_statuses);
        $display("Tokens seen: prefix %0d, command %0d, middle %0d, trailing %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (fail_count == 0 && due_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
